// File: hdl/fcl_pkg.sv
// Shared types and constants of the FAT cluster locate unit.
package fcl_pkg;

    localparam int CLUSTER_W = 28;
    localparam int BYTES_W   = 32;
    localparam int SECTOR_W  = 32;
    localparam int OFFSET_W  = 15;
    localparam int ENTRY_W   = 28;
    localparam int SPC_W     = 8;
    localparam int BLOCK_W   = 13;
    localparam int BIAS_W    = 16;
    localparam int FS_W      = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // Bit position is cluster * 32 at most; the divider works on it after dropping three bits.
    localparam int POS_W  = CLUSTER_W + 5;
    localparam int POS8_W = POS_W - 3;

    localparam logic KIND_LOCATE  = 1'b0;
    localparam logic KIND_EXTRACT = 1'b1;

    localparam logic [FS_W-1:0] FS_FAT12 = 2'd0;
    localparam logic [FS_W-1:0] FS_FAT16 = 2'd1;
    localparam logic [FS_W-1:0] FS_FAT32 = 2'd2;

    localparam logic [11:0] ENTRY12_MASK = 12'h0FFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FS_TYPE           = 3'd0,
        REG_FIRST_FAT_SECTOR  = 3'd1,
        REG_FIRST_DATA_SECTOR = 3'd2,
        REG_SECTORS_PER_CLUS  = 3'd3,
        REG_BLOCK_SIZE        = 3'd4,
        REG_CLUSTER_BIAS      = 3'd5
    } fcl_reg_idx_t;

    typedef struct packed {
        logic                 kind;
        logic [CLUSTER_W-1:0] cluster_number;
        logic [BYTES_W-1:0]   entry_bytes;
    } fcl_in_t;

    typedef struct packed {
        logic [SECTOR_W-1:0] fat_sector;
        logic [OFFSET_W-1:0] bit_offset;
        logic [SECTOR_W-1:0] data_sector;
        logic [ENTRY_W-1:0]  entry_value;
    } fcl_out_t;

    typedef struct packed {
        logic [FS_W-1:0]     fs_type;
        logic [SECTOR_W-1:0] first_fat_sector;
        logic [SECTOR_W-1:0] first_data_sector;
        logic [SPC_W-1:0]    sectors_per_cluster;
        logic [BLOCK_W-1:0]  block_size;
        logic [BIAS_W-1:0]   cluster_bias;
    } fcl_cfg_t;

    // Values that ride alongside the divider.
    typedef struct packed {
        logic                kind;
        logic [2:0]          pos_low;
        logic [SECTOR_W-1:0] product;
        logic [ENTRY_W-1:0]  entry;
    } fcl_side_t;

endpackage

// File: hdl/fcl_cfg_regs.sv
// Configuration registers and the effective block size derived from them.
module fcl_cfg_regs #(
    parameter int MAX_BLOCK_BYTES = 4096,
    parameter int EBW             = 13
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fcl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fcl_pkg::CFG_DATA_W-1:0]    cfg_data,
    output fcl_pkg::fcl_cfg_t                 cfg,
    output logic [EBW-1:0]                    block_eff
);
    import fcl_pkg::*;

    fcl_cfg_t       cfg_reg;
    fcl_cfg_t       cfg_next;
    logic [EBW-1:0] block_eff_reg;
    logic [EBW-1:0] block_eff_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;
    assign block_eff = block_eff_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_FS_TYPE:           cfg_next.fs_type = cfg_data[FS_W-1:0];
                REG_FIRST_FAT_SECTOR:  cfg_next.first_fat_sector = cfg_data[SECTOR_W-1:0];
                REG_FIRST_DATA_SECTOR: cfg_next.first_data_sector = cfg_data[SECTOR_W-1:0];
                REG_SECTORS_PER_CLUS:  cfg_next.sectors_per_cluster = cfg_data[SPC_W-1:0];
                REG_BLOCK_SIZE:        cfg_next.block_size = cfg_data[BLOCK_W-1:0];
                REG_CLUSTER_BIAS:      cfg_next.cluster_bias = cfg_data[BIAS_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    // A zero block size counts as one byte; large sizes clamp to the supported maximum.
    always_comb begin
        if (cfg_reg.block_size == '0) begin
            block_eff_next = EBW'(1);
        end else if (32'(cfg_reg.block_size) > 32'(MAX_BLOCK_BYTES)) begin
            block_eff_next = EBW'(MAX_BLOCK_BYTES);
        end else begin
            block_eff_next = EBW'(cfg_reg.block_size);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fs_type             <= FS_FAT16;
            cfg_reg.first_fat_sector    <= 32'd1;
            cfg_reg.first_data_sector   <= 32'd1;
            cfg_reg.sectors_per_cluster <= 8'd8;
            cfg_reg.block_size          <= 13'd512;
            cfg_reg.cluster_bias        <= 16'd2;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_ff @(posedge aclk) begin
        block_eff_reg <= block_eff_next;
    end

endmodule

// File: hdl/fcl_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband word.
module fcl_divider #(
    parameter int DIV_W = 13
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [fcl_pkg::POS8_W-1:0]     in_dividend,
    input  fcl_pkg::fcl_side_t             in_side,
    input  logic [DIV_W-1:0]               divisor,
    output logic                           out_valid,
    output logic [fcl_pkg::POS8_W-1:0]     out_quot,
    output logic [DIV_W-1:0]               out_rem,
    output fcl_pkg::fcl_side_t             out_side
);
    import fcl_pkg::*;

    localparam int N = POS8_W;

    logic              vld_reg  [N];
    logic [DIV_W-1:0]  rem_reg  [N];
    logic [N-1:0]      quot_reg [N];
    logic [N-1:0]      dvd_reg  [N];
    fcl_side_t         side_reg [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic             v_in;
        logic [DIV_W-1:0] rem_in;
        logic [N-1:0]     q_in;
        logic [N-1:0]     d_in;
        fcl_side_t        s_in;
        logic [DIV_W:0]   shifted;
        logic             ge;
        logic [DIV_W:0]   diff;
        logic [DIV_W-1:0] rem_next;
        logic [N-1:0]     q_next;

        if (k == 0) begin : g_first
            assign v_in   = in_valid;
            assign rem_in = '0;
            assign q_in   = '0;
            assign d_in   = in_dividend;
            assign s_in   = in_side;
        end else begin : g_rest
            assign v_in   = vld_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign q_in   = quot_reg[k-1];
            assign d_in   = dvd_reg[k-1];
            assign s_in   = side_reg[k-1];
        end

        always_comb begin
            shifted  = {rem_in, d_in[N-1-k]};
            ge       = (shifted >= {1'b0, divisor});
            diff     = shifted - {1'b0, divisor};
            rem_next = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            q_next   = q_in;
            q_next[N-1-k] = ge;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                quot_reg[k] <= q_next;
                dvd_reg[k]  <= d_in;
                side_reg[k] <= s_in;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_quot  = quot_reg[N-1];
    assign out_rem   = rem_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

// File: hdl/fcl_out_buf.sv
// Output register with a skid word so the pipeline keeps moving while a result waits.
module fcl_out_buf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  fcl_pkg::fcl_out_t   in_data,
    output logic                pipe_en,
    output logic                m_valid,
    input  logic                m_ready,
    output fcl_pkg::fcl_out_t   m_data
);
    import fcl_pkg::*;

    logic     m_valid_reg;
    logic     m_valid_next;
    fcl_out_t m_data_reg;
    fcl_out_t m_data_next;
    logic     skid_valid_reg;
    logic     skid_valid_next;
    fcl_out_t skid_data_reg;
    fcl_out_t skid_data_next;
    logic     out_free;

    // The pipeline only stalls once the skid word is occupied, so pipe_en comes from a flop.
    assign pipe_en  = !skid_valid_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (out_free) begin
                m_valid_next    = 1'b1;
                m_data_next     = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (in_valid) begin
            if (out_free) begin
                m_valid_next = 1'b1;
                m_data_next  = in_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = in_data;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// File: hdl/fat_cluster_locate_unit.sv
// Top level of the FAT cluster locate unit: input, address, divider and finish stages.
//
//  channel | ports                                      | word
//  --------+--------------------------------------------+-------------------------
//  input   | s_valid, s_ready, s_data                   | fcl_in_t
//  result  | m_valid, m_ready, m_data                   | fcl_out_t
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data  | register index and value
//
// One word is accepted per cycle while s_ready is high; each passes through the input register,
// address stage, 30 divider stages of one quotient bit each, finish stage and output register.
// The divider chain is pipelined, so throughput stays at one word per cycle while s_ready is high.
// Reset is synchronous and active low; it empties the pipeline and restores the registers.
// When a result waits at the output, one more result parks in a skid word, and only then
// does s_ready drop and the whole pipeline hold in place.
module fat_cluster_locate_unit #(
    parameter int MAX_BLOCK_BYTES = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  fcl_pkg::fcl_in_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output fcl_pkg::fcl_out_t              m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fcl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fcl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fcl_pkg::*;

    localparam int EBW = $clog2(MAX_BLOCK_BYTES + 1);

    fcl_cfg_t         cfg;
    logic [EBW-1:0]   block_eff;
    logic             pipe_en;

    logic             s0_valid_reg;
    fcl_in_t          s0_data_reg;

    logic             s1_valid_reg;
    logic [POS8_W-1:0] s1_dividend_reg;
    fcl_side_t        s1_side_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] clus_wide;
    logic [SECTOR_W-1:0] diff_next;
    logic [SECTOR_W+SPC_W-1:0] prod_full;
    logic [15:0]      word16;
    logic [ENTRY_W-1:0] entry_dec;
    fcl_side_t        side_next;

    logic             div_valid;
    logic [POS8_W-1:0] div_quot;
    logic [EBW-1:0]   div_rem;
    fcl_side_t        div_side;

    logic             fin_valid_reg;
    fcl_out_t         fin_data_reg;
    fcl_out_t         fin_data_next;
    logic [EBW+2:0]   offset_full;

    assign s_ready = pipe_en;

    fcl_cfg_regs #(
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES),
        .EBW             (EBW)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .block_eff (block_eff)
    );

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s0_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s0_data_reg <= s_data;
        end
    end

    // Address stage: bit position, cluster to sector product and entry decode.
    always_comb begin
        clus_wide = POS_W'(s0_data_reg.cluster_number);
        word16    = s0_data_reg.entry_bytes[15:0];
        unique case (cfg.fs_type)
            FS_FAT12: begin
                pos_next = (clus_wide << 3) + (clus_wide << 2);
                if (s0_data_reg.cluster_number[0]) begin
                    entry_dec = ENTRY_W'(word16[15:4]);
                end else begin
                    entry_dec = ENTRY_W'(word16[11:0] & ENTRY12_MASK);
                end
            end
            FS_FAT16: begin
                pos_next  = clus_wide << 4;
                entry_dec = ENTRY_W'(word16);
            end
            default: begin
                pos_next  = clus_wide << 5;
                entry_dec = s0_data_reg.entry_bytes[ENTRY_W-1:0];
            end
        endcase
        diff_next = SECTOR_W'(s0_data_reg.cluster_number) - SECTOR_W'(cfg.cluster_bias);
        prod_full = (SECTOR_W + SPC_W)'(diff_next) * (SECTOR_W + SPC_W)'(cfg.sectors_per_cluster);
        side_next.kind    = s0_data_reg.kind;
        side_next.pos_low = pos_next[2:0];
        side_next.product = prod_full[SECTOR_W-1:0];
        side_next.entry   = (s0_data_reg.kind == KIND_EXTRACT) ? entry_dec : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s1_dividend_reg <= pos_next[POS_W-1:3];
            s1_side_reg     <= side_next;
        end
    end

    // Dividing pos/8 by the block size in bytes gives the sector; the low three bits
    // rejoin the remainder to form the bit offset.
    fcl_divider #(
        .DIV_W (EBW)
    ) u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (pipe_en),
        .in_valid    (s1_valid_reg),
        .in_dividend (s1_dividend_reg),
        .in_side     (s1_side_reg),
        .divisor     (block_eff),
        .out_valid   (div_valid),
        .out_quot    (div_quot),
        .out_rem     (div_rem),
        .out_side    (div_side)
    );

    // Finish stage.
    always_comb begin
        offset_full = {div_rem, div_side.pos_low};
        fin_data_next.data_sector = cfg.first_data_sector + div_side.product;
        fin_data_next.entry_value = div_side.entry;
        if (div_side.kind == KIND_LOCATE) begin
            fin_data_next.fat_sector = cfg.first_fat_sector + SECTOR_W'(div_quot);
            fin_data_next.bit_offset = OFFSET_W'(offset_full);
        end else begin
            fin_data_next.fat_sector = '0;
            fin_data_next.bit_offset = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            fin_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            fin_data_reg <= fin_data_next;
        end
    end

    fcl_out_buf u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (fin_valid_reg && pipe_en),
        .in_data  (fin_data_reg),
        .pipe_en  (pipe_en),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
